@@ hdl/lfu_page_replacement_defines.svh @@
// Assertion macros for the LFU page replacement block.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant, disabled while in reset.
`define LFU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ hdl/lfupr_pkg.sv @@
// Shared types and constants for the LFU page replacement block.
`timescale 1ns / 1ps

package lfupr_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int COUNT_BITS  = 16;
  localparam int FAULT_BITS  = 16;
  localparam int CFG_BITS    = 4;
  localparam int CMP_BITS    = 8;
  localparam int IDX_BITS    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_BITS   = IDX_BITS;
  localparam int VT_BITS     = $clog2(MAX_FRAMES + 1);
  localparam logic [CFG_BITS-1:0] FRAME_COUNT_RST = CFG_BITS'(8);

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_FILL  = 2'd1,
    OP_EVICT = 2'd2
  } upd_op_t;

  // Record that walks the frame chain, one cell per cycle.
  typedef struct packed {
    logic                  tok;
    logic [PAGE_BITS-1:0]  page;
    logic                  found;
    logic [IDX_BITS-1:0]   hit_slot;
    logic                  free_found;
    logic [IDX_BITS-1:0]   free_slot;
    logic                  best_found;
    logic [IDX_BITS-1:0]   best_slot;
    logic [PAGE_BITS-1:0]  best_page;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [RANK_BITS-1:0]  best_rank;
    logic [VT_BITS-1:0]    vt;
  } scan_t;

  // Update broadcast to all cells at the end of a reference.
  typedef struct packed {
    logic                 en;
    upd_op_t              op;
    logic [IDX_BITS-1:0]  slot;
    logic [PAGE_BITS-1:0] page;
    logic [RANK_BITS-1:0] rank_ev;
    logic [RANK_BITS-1:0] rank_new;
  } upd_t;

endpackage

@@ hdl/lfupr_cell.sv @@
// One page frame: holds its page, use count and load rank, and scans the passing record.
`timescale 1ns / 1ps

module lfupr_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lfupr_pkg::IDX_BITS-1:0] idx,
  input  logic                          active,
  input  lfupr_pkg::scan_t              rec_i,
  output lfupr_pkg::scan_t              rec_o,
  input  lfupr_pkg::upd_t               upd_i,
  output logic                          valid_o
);
  import lfupr_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [RANK_BITS-1:0]  rank_r, rank_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  scan_t                 rec_r, rec_nxt;
  logic                  sel;

  assign sel     = (upd_i.slot == idx);
  assign rec_o   = rec_r;
  assign valid_o = valid_r;

  always_comb begin
    rec_nxt    = rec_i;
    rec_nxt.vt = rec_i.vt + VT_BITS'(valid_r);
    if (active) begin
      if (valid_r && (page_r == rec_i.page) && !rec_i.found) begin
        rec_nxt.found    = 1'b1;
        rec_nxt.hit_slot = idx;
      end
      if (!valid_r && !rec_i.free_found) begin
        rec_nxt.free_found = 1'b1;
        rec_nxt.free_slot  = idx;
      end
      if (valid_r && (!rec_i.best_found || (cnt_r < rec_i.best_cnt) ||
          ((cnt_r == rec_i.best_cnt) && (rank_r < rec_i.best_rank)))) begin
        rec_nxt.best_found = 1'b1;
        rec_nxt.best_slot  = idx;
        rec_nxt.best_page  = page_r;
        rec_nxt.best_cnt   = cnt_r;
        rec_nxt.best_rank  = rank_r;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    cnt_nxt   = cnt_r;
    if (upd_i.en) begin
      case (upd_i.op)
        OP_HIT: begin
          if (sel && (cnt_r != '1)) cnt_nxt = cnt_r + COUNT_BITS'(1);
        end
        OP_FILL: begin
          if (sel) begin
            valid_nxt = 1'b1;
            page_nxt  = upd_i.page;
            cnt_nxt   = COUNT_BITS'(1);
            rank_nxt  = upd_i.rank_new;
          end
        end
        OP_EVICT: begin
          if (sel) begin
            page_nxt = upd_i.page;
            cnt_nxt  = COUNT_BITS'(1);
            rank_nxt = upd_i.rank_new;
          end else if (valid_r && (rank_r > upd_i.rank_ev)) begin
            rank_nxt = rank_r - RANK_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      rec_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      rec_r   <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

@@ hdl/lfu_page_replacement.sv @@
// LFU page replacement, oldest-load tie break, built as a chain of frame cells.
// One reference in flight; the record crosses one frame cell per cycle, and a new
//   reference is taken only once the last one has committed its result.
// Reset: synchronous, active low; clears frame valid bits, load ranks and the
//   fault total, sets frame_count to 8. No clearing pass.
`timescale 1ns / 1ps

module lfu_page_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lfupr_pkg::CFG_BITS-1:0]  cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lfupr_pkg::PAGE_BITS-1:0] in_page_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic                            out_evicted_valid,
  output logic [lfupr_pkg::PAGE_BITS-1:0] out_evicted_page,
  output logic [lfupr_pkg::FAULT_BITS-1:0] out_fault_total
);
  import lfupr_pkg::*;

  `include "lfu_page_replacement_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CFG_BITS-1:0]    frame_count_r;
  logic [CMP_BITS-1:0]    fc_ext, act;
  logic [MAX_FRAMES-1:0]  act_mask, valid_vec, tok_vec;
  scan_t                  chain [MAX_FRAMES+1];
  scan_t                  seed, last, fin_r;
  upd_t                   upd;
  logic [FAULT_BITS-1:0]  fault_r, fault_nxt;
  logic                   out_valid_r, out_hit_r, out_ev_valid_r;
  logic [PAGE_BITS-1:0]   out_ev_page_r;
  logic [FAULT_BITS-1:0]  out_fault_r;
  logic                   accept, out_free, commit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_UPD) && out_free;
  assign last     = chain[MAX_FRAMES];

  always_comb begin
    fc_ext = CMP_BITS'(frame_count_r);
    if (fc_ext == '0) act = CMP_BITS'(1);
    else if (fc_ext > CMP_BITS'(MAX_FRAMES)) act = CMP_BITS'(MAX_FRAMES);
    else act = fc_ext;
  end

  always_comb begin
    seed      = '0;
    seed.tok  = accept;
    seed.page = in_page_number;
  end

  assign chain[0] = seed;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign act_mask[i] = (CMP_BITS'(i) < act);
    assign tok_vec[i]  = chain[i+1].tok;
    lfupr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_BITS'(i)),
      .active  (act_mask[i]),
      .rec_i   (chain[i]),
      .rec_o   (chain[i+1]),
      .upd_i   (upd),
      .valid_o (valid_vec[i])
    );
  end

  always_comb begin
    upd          = '0;
    upd.en       = commit;
    upd.page     = fin_r.page;
    upd.rank_ev  = fin_r.best_rank;
    if (fin_r.found) begin
      upd.op   = OP_HIT;
      upd.slot = fin_r.hit_slot;
    end else if (fin_r.free_found) begin
      upd.op       = OP_FILL;
      upd.slot     = fin_r.free_slot;
      upd.rank_new = RANK_BITS'(fin_r.vt);
    end else begin
      upd.op       = OP_EVICT;
      upd.slot     = fin_r.best_slot;
      upd.rank_new = RANK_BITS'(fin_r.vt - VT_BITS'(1));
    end
  end

  always_comb begin
    fault_nxt = fault_r;
    if (!fin_r.found && (fault_r != '1)) fault_nxt = fault_r + FAULT_BITS'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (last.tok) state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= FRAME_COUNT_RST;
      fault_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) frame_count_r <= cfg_wr_data;
      if (commit) begin
        fault_r     <= fault_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && last.tok) fin_r <= last;
    if (commit) begin
      out_hit_r      <= fin_r.found;
      out_ev_valid_r <= (upd.op == OP_EVICT);
      out_ev_page_r  <= (upd.op == OP_EVICT) ? fin_r.best_page : '0;
      out_fault_r    <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;

  `LFU_ASSERT_ALWAYS(a_one_record, $onehot0(tok_vec), "more than one record in the chain")
  `LFU_ASSERT_NOW(a_tok_in_scan, last.tok, state_r == ST_SCAN, "record left chain outside scan")
  `LFU_ASSERT_NOW(a_evict_full, upd.en && (upd.op == OP_EVICT), &(valid_vec | ~act_mask), "evict with a free frame")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the LFU page replacement block with oldest-load tie break.
`timescale 1ns / 1ps

module testbench;
  import lfupr_pkg::*;

  localparam int     LATENCY     = MAX_FRAMES + 2;
  localparam int     STALL_LIMIT = 5000;
  localparam longint COUNT_MAX   = (64'd1 << COUNT_BITS) - 1;
  localparam longint FAULT_MAX   = (64'd1 << FAULT_BITS) - 1;

  typedef struct packed {
    logic                  hit;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_BITS-1:0] fault_total;
  } lfu_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0]   cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PAGE_BITS-1:0]  in_page_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic                  out_evicted_valid;
  logic [PAGE_BITS-1:0]  out_evicted_page;
  logic [FAULT_BITS-1:0] out_fault_total;

  lfu_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // frame table mirror
  logic [PAGE_BITS-1:0] fr_page  [MAX_FRAMES];
  bit                   fr_valid [MAX_FRAMES];
  longint               fr_uses  [MAX_FRAMES];
  int                   fr_rank  [MAX_FRAMES];
  longint               fault_cnt;
  logic [CFG_BITS-1:0]  frame_cnt;

  logic [PAGE_BITS-1:0] ref_pages_q [$];
  lfu_result_t          lookup_expect_q [$];

  int  refs_queued = 0;
  int  refs_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  evictions_seen = 0;
  int  cfg_writes = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  in_fire = 1'b0;
  bit  no_idle = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  rx_open = 1'b1;

  function automatic lfu_result_t lfu_lookup(logic [PAGE_BITS-1:0] page);
    lfu_result_t res;
    int          act;
    int          slot;
    int          best;
    int          rank_ev;
    int          nvalid;
    bit          found;
    bit          have_free;
    res = '0;
    act = (frame_cnt == 0) ? 1 : (frame_cnt > MAX_FRAMES) ? MAX_FRAMES : int'(frame_cnt);
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < act; i++) begin
      if (!found && fr_valid[i] && fr_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (fr_uses[slot] < COUNT_MAX) fr_uses[slot]++;
    end else begin
      if (fault_cnt < FAULT_MAX) fault_cnt++;
      have_free = 1'b0;
      for (int i = 0; i < act; i++) begin
        if (!have_free && !fr_valid[i]) begin
          have_free = 1'b1;
          slot = i;
        end
      end
      if (!have_free) begin
        // lowest use count, oldest load wins a tie
        best = 0;
        for (int i = 1; i < act; i++) begin
          if (fr_uses[i] < fr_uses[best] ||
              (fr_uses[i] == fr_uses[best] && fr_rank[i] < fr_rank[best]))
            best = i;
        end
        slot = best;
        res.evicted_valid = 1'b1;
        res.evicted_page = fr_page[slot];
        rank_ev = fr_rank[slot];
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (fr_valid[i] && fr_rank[i] > rank_ev) fr_rank[i]--;
        end
        fr_valid[slot] = 1'b0;
      end
      nvalid = 0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (fr_valid[i]) nvalid++;
      end
      fr_rank[slot]  = nvalid;
      fr_valid[slot] = 1'b1;
      fr_page[slot]  = page;
      fr_uses[slot]  = 1;
    end
    res.fault_total = fault_cnt[FAULT_BITS-1:0];
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // sample side: model update, result check, watchdog
  always @(posedge clk) begin
    lfu_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        fr_page[i]  = '0;
        fr_valid[i] = 1'b0;
        fr_uses[i]  = 0;
        fr_rank[i]  = 0;
      end
      fault_cnt = 0;
      frame_cnt = FRAME_COUNT_RST;
      idle_cycles = 0;
    end else begin
      if (cfg_wr_en) frame_cnt = cfg_wr_data;
      if (out_valid && out_ready) begin
        results_seen++;
        if (lookup_expect_q.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing pending, hit=%0b ev=%0b page=0x%0h faults=%0d",
                   $time, out_hit, out_evicted_valid, out_evicted_page, out_fault_total);
        end else begin
          want = lookup_expect_q.pop_front();
          if (want.hit) hits_seen++;
          if (want.evicted_valid) evictions_seen++;
          check_field("hit", longint'(want.hit), longint'(out_hit));
          check_field("evicted_valid", longint'(want.evicted_valid),
                      longint'(out_evicted_valid));
          check_field("evicted_page", longint'(want.evicted_page),
                      longint'(out_evicted_page));
          check_field("fault_total", longint'(want.fault_total),
                      longint'(out_fault_total));
        end
      end
      if (in_valid && in_ready) begin
        lookup_expect_q.insert(lookup_expect_q.size(), lfu_lookup(in_page_number));
        refs_sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d results pending",
                 $time, STALL_LIMIT, lookup_expect_q.size());
        $display("Verification failed");
        $finish;
      end
    end
    in_fire <= rst_n && in_valid && in_ready;
  end

  // page reference driver: bursts with random gaps
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (gap_left > 0 && !no_idle) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ref_pages_q.size() > 0) begin
        in_valid <= 1'b1;
        in_page_number <= ref_pages_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: open and stalled runs of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      rx_open = ($urandom_range(0, 2) != 0);
      stall_left = rx_open ? $urandom_range(0, 24) : $urandom_range(1, 12);
    end
    out_ready <= rx_open || no_idle;
  end

  task automatic queue_ref(logic [PAGE_BITS-1:0] page);
    ref_pages_q.insert(ref_pages_q.size(), page);
    refs_queued++;
  endtask

  // mostly a small hot set so hits and evictions mix, some wide-range noise
  task automatic queue_random_refs(int n);
    logic [PAGE_BITS-1:0] hot_base;
    int                   spread;
    hot_base = '0;
    spread = 1;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) begin
        hot_base = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
        spread = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 19) == 0)
        queue_ref(PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1)));
      else if ($urandom_range(0, 1) == 0)
        queue_ref(hot_base + PAGE_BITS'($urandom_range(0, 2)));
      else
        queue_ref(hot_base + PAGE_BITS'($urandom_range(0, spread)));
    end
  endtask

  task automatic wait_drained();
    while (refs_sent != refs_queued || lookup_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_frame_count(logic [CFG_BITS-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [CFG_BITS-1:0] sweep [12];
    sweep = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd5, 4'd15, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6, 4'd12};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill all eight frames, then evict on count and on load order
    queue_ref(16'h0000); queue_ref(16'hFFFF); queue_ref(16'h0000); queue_ref(16'hAAAA);
    queue_ref(16'h5555); queue_ref(16'h0001); queue_ref(16'h0002); queue_ref(16'h0003);
    queue_ref(16'h0004); queue_ref(16'h8000); queue_ref(16'h0001); queue_ref(16'h7FFF);
    // two frames: pages left in upper frames go dormant
    write_frame_count(4'd2);
    queue_ref(16'h0002); queue_ref(16'h0002); queue_ref(16'h1234);
    // zero frames acts as one
    write_frame_count(4'd0);
    queue_ref(16'h0002); queue_ref(16'h00FF); queue_ref(16'h00FF);
    // above the maximum acts as eight; dormant frames wake with duplicates
    write_frame_count(4'd15);
    queue_ref(16'h0002); queue_ref(16'h0004); queue_ref(16'hFFFF); queue_ref(16'h3C3C);

    foreach (sweep[k]) begin
      write_frame_count(sweep[k]);
      queue_random_refs($urandom_range(95, 115));
    end

    // back-to-back faults on a single frame
    write_frame_count(4'd1);
    wait_drained();
    no_idle = 1'b1;
    for (int j = 0; j < 64; j++) queue_ref(j[0] ? 16'hF0F0 : 16'h0F0F);
    wait_drained();
    no_idle = 1'b0;
    write_frame_count(4'd8);
    queue_random_refs(40);

    wait_drained();
    repeat (4 * LATENCY) @(negedge clk);
    $display("Run: %0d references, %0d results (%0d hits, %0d evictions), %0d frame-count writes",
             refs_sent, results_seen, hits_seen, evictions_seen, cfg_writes);
    $display("Frame counts 0 to 15 with dormant frames, stalls and a back-to-back fault run; %0d faults",
             fault_cnt);
    if (errors == 0 && lookup_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
